### rtl/core/mbd_pkg.sv
// Shared constants and types for the multi-button history debouncer.
package mbd_pkg;

    localparam int unsigned CHANNELS = 8;
    localparam int unsigned FIELD_W  = 8;
    localparam int unsigned LANES    = (CHANNELS < FIELD_W) ? CHANNELS : FIELD_W;
    localparam int unsigned HIST_W   = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [HIST_W-1:0] HIST_MASK     = 16'b1111_0000_0011_1111;
    localparam logic [HIST_W-1:0] HIST_RISE_PAT = 16'b0000_0000_0011_1111;
    localparam logic [HIST_W-1:0] HIST_FALL_PAT = 16'b1111_0000_0000_0000;
    localparam logic [HIST_W-1:0] HIST_ONES     = 16'hffff;
    localparam logic [HIST_W-1:0] HIST_ZERO     = 16'h0000;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ENABLE = 1'b1;

    typedef struct packed {
        logic press;
        logic release_evt;
        logic held;
    } t_lane_res;

endpackage

### rtl/core/mbd_lane.sv
// One debounce lane: sample history, pattern match and held flag.
module mbd_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_en,
    input  logic                i_level,
    input  logic                i_active_low,
    output mbd_pkg::t_lane_res  o_res
);

    logic [mbd_pkg::HIST_W-1:0] r_hist;
    logic [mbd_pkg::HIST_W-1:0] n_hist;
    logic                       r_held;
    logic                       n_held;
    logic [mbd_pkg::HIST_W-1:0] shifted;
    logic [mbd_pkg::HIST_W-1:0] after_down;
    logic                       rise_a;
    logic                       fall_a;
    logic                       rise_b;
    logic                       fall_b;
    logic                       down;
    logic                       up;
    logic                       press;

    always_comb begin
        shifted = {r_hist[mbd_pkg::HIST_W-2:0], i_level};
        rise_a  = (shifted & mbd_pkg::HIST_MASK) == mbd_pkg::HIST_RISE_PAT;
        fall_a  = (shifted & mbd_pkg::HIST_MASK) == mbd_pkg::HIST_FALL_PAT;
        down    = i_active_low ? fall_a : rise_a;
        if (down) begin
            after_down = i_active_low ? mbd_pkg::HIST_ZERO : mbd_pkg::HIST_ONES;
        end else begin
            after_down = shifted;
        end
        rise_b = (after_down & mbd_pkg::HIST_MASK) == mbd_pkg::HIST_RISE_PAT;
        fall_b = (after_down & mbd_pkg::HIST_MASK) == mbd_pkg::HIST_FALL_PAT;
        press  = down && !r_held;
        up     = !press && (i_active_low ? rise_b : fall_b);
        n_hist = after_down;
        n_held = r_held;
        if (up) begin
            n_hist = i_active_low ? mbd_pkg::HIST_ONES : mbd_pkg::HIST_ZERO;
        end
        if (press) begin
            n_held = 1'b1;
        end else if (up) begin
            n_held = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= mbd_pkg::HIST_ONES;
            r_held <= 1'b0;
        end else if (i_adv && i_en) begin
            r_hist <= n_hist;
            r_held <= n_held;
        end
    end

    assign o_res.press       = i_en && press;
    assign o_res.release_evt = i_en && up;
    assign o_res.held        = i_en ? n_held : r_held;

endmodule

### rtl/core/multi_button_history_debouncer.sv
// Top level of the multi-button history debouncer.
//
// Input channel: i_valid / o_stall carry one sampling tick, i_levels holds the
// raw pin level of every button. Output channel: o_valid / i_stall carry one
// result per tick with press, release and held masks.
// Each accepted tick updates all enabled lanes in parallel and its result sits
// in the output register on the next cycle; throughput is one transaction per
// cycle while the receiver does not stall. The lane update is a 16-bit pattern
// compare per channel between the input port and the result register.
// While the receiver stalls, the result holds and o_stall rises so that no
// further tick is taken; a tick is taken in the same cycle as the waiting
// result leaves.
// Configuration: i_cfg_we with i_cfg_idx selects active_low (index 0) or
// channel_enable (index 1); a write takes effect from the next tick.
// Reset: histories go to all ones, held flags clear, active_low to 1 and all
// channels enabled; the output register is empty.
module multi_button_history_debouncer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [mbd_pkg::FIELD_W-1:0]     i_levels,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [mbd_pkg::FIELD_W-1:0]     o_press_events,
    output logic [mbd_pkg::FIELD_W-1:0]     o_release_events,
    output logic [mbd_pkg::FIELD_W-1:0]     o_pressed_now,
    input  logic                            i_cfg_we,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                           r_active_low;
    logic [mbd_pkg::FIELD_W-1:0]    r_chan_en;
    logic                           r_valid;
    logic [mbd_pkg::FIELD_W-1:0]    r_press;
    logic [mbd_pkg::FIELD_W-1:0]    r_release;
    logic [mbd_pkg::FIELD_W-1:0]    r_held;
    logic [mbd_pkg::FIELD_W-1:0]    n_press;
    logic [mbd_pkg::FIELD_W-1:0]    n_release;
    logic [mbd_pkg::FIELD_W-1:0]    n_held;
    logic                           accept;
    mbd_pkg::t_lane_res             lane_res [mbd_pkg::LANES];

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    for (genvar g = 0; g < mbd_pkg::LANES; g++) begin : g_lane
        mbd_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_adv        (accept),
            .i_en         (r_chan_en[g]),
            .i_level      (i_levels[g]),
            .i_active_low (r_active_low),
            .o_res        (lane_res[g])
        );
    end

    always_comb begin
        n_press   = '0;
        n_release = '0;
        n_held    = '0;
        for (int i = 0; i < mbd_pkg::LANES; i++) begin
            n_press[i]   = lane_res[i].press;
            n_release[i] = lane_res[i].release_evt;
            n_held[i]    = lane_res[i].held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low <= 1'b1;
            r_chan_en    <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mbd_pkg::CFG_ACTIVE_LOW: begin
                    r_active_low <= i_cfg_data[0];
                end
                mbd_pkg::CFG_CHANNEL_ENABLE: begin
                    r_chan_en <= i_cfg_data[mbd_pkg::FIELD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_press   <= n_press;
            r_release <= n_release;
            r_held    <= n_held;
        end
    end

    assign o_valid          = r_valid;
    assign o_press_events   = r_press;
    assign o_release_events = r_release;
    assign o_pressed_now    = r_held;

    a_no_press_and_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_press_events & o_release_events) == '0))
        else $error("press and release on the same channel");

    a_press_sets_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_press_events & ~o_pressed_now) == '0))
        else $error("press without held flag");

    a_release_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_release_events & o_pressed_now) == '0))
        else $error("release with held flag still set");

    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_events_only_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_cfg_we |=> ((o_press_events | o_release_events)
            & ~$past(r_chan_en)) == '0)
        else $error("event on a disabled channel");

endmodule

### sim/multi_button_history_debouncer_tb.sv
// Self-checking testbench for the multi-button history debouncer: random ticks, predicted masks.
module multi_button_history_debouncer_tb;

    class debounce_checker;
        typedef struct packed {
            logic [mbd_pkg::FIELD_W-1:0] press_mask;
            logic [mbd_pkg::FIELD_W-1:0] release_mask;
            logic [mbd_pkg::FIELD_W-1:0] held_mask;
        } t_tick_masks;

        logic [mbd_pkg::HIST_W-1:0]  history [mbd_pkg::LANES];
        logic [mbd_pkg::FIELD_W-1:0] held;
        logic                        active_low;
        logic [mbd_pkg::FIELD_W-1:0] enable;
        t_tick_masks                 expected_masks [$];
        int                          errors;

        function new();
            for (int i = 0; i < mbd_pkg::LANES; i++) history[i] = mbd_pkg::HIST_ONES;
            held       = '0;
            active_low = 1'b1;
            enable     = '1;
            errors     = 0;
        endfunction

        function int pending();
            return expected_masks.size();
        endfunction

        function void accept_tick(logic [mbd_pkg::FIELD_W-1:0] levels);
            t_tick_masks                res;
            logic [mbd_pkg::HIST_W-1:0] h;
            logic                       down;
            logic                       up;
            res = '0;
            for (int i = 0; i < mbd_pkg::LANES; i++) begin
                if (enable[i]) begin
                    h = {history[i][mbd_pkg::HIST_W-2:0], levels[i]};
                    down = active_low
                        ? ((h & mbd_pkg::HIST_MASK) == mbd_pkg::HIST_FALL_PAT)
                        : ((h & mbd_pkg::HIST_MASK) == mbd_pkg::HIST_RISE_PAT);
                    if (down) h = active_low ? mbd_pkg::HIST_ZERO : mbd_pkg::HIST_ONES;
                    if (down && !held[i]) begin
                        held[i] = 1'b1;
                        res.press_mask[i] = 1'b1;
                    end else begin
                        up = active_low
                            ? ((h & mbd_pkg::HIST_MASK) == mbd_pkg::HIST_RISE_PAT)
                            : ((h & mbd_pkg::HIST_MASK) == mbd_pkg::HIST_FALL_PAT);
                        if (up) begin
                            h = active_low ? mbd_pkg::HIST_ONES : mbd_pkg::HIST_ZERO;
                            held[i] = 1'b0;
                            res.release_mask[i] = 1'b1;
                        end
                    end
                    history[i] = h;
                end
            end
            res.held_mask = held;
            expected_masks.push_back(res);
        endfunction

        task flag_mismatch(input string msg);
            errors++;
            $display("%0t: mismatch: %s", $time, msg);
        endtask

        task compare_result(input logic [mbd_pkg::FIELD_W-1:0] press,
                            input logic [mbd_pkg::FIELD_W-1:0] rel,
                            input logic [mbd_pkg::FIELD_W-1:0] hold);
            t_tick_masks want;
            if (expected_masks.size() == 0) begin
                flag_mismatch("result transaction with no tick waiting");
            end else begin
                want = expected_masks.pop_front();
                if (press !== want.press_mask)
                    flag_mismatch($sformatf("press_events %02h, predicted %02h",
                                            press, want.press_mask));
                if (rel !== want.release_mask)
                    flag_mismatch($sformatf("release_events %02h, predicted %02h",
                                            rel, want.release_mask));
                if (hold !== want.held_mask)
                    flag_mismatch($sformatf("pressed_now %02h, predicted %02h",
                                            hold, want.held_mask));
            end
        endtask
    endclass

    localparam int HOLD_CYCLES = 60;
    localparam int SEGMENTS    = 7;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_valid    = 1'b0;
    logic [mbd_pkg::FIELD_W-1:0]    i_levels   = '0;
    logic                           i_stall    = 1'b0;
    logic                           i_cfg_we   = 1'b0;
    logic [mbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = mbd_pkg::CFG_ACTIVE_LOW;
    logic [mbd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           o_stall;
    logic                           o_valid;
    logic [mbd_pkg::FIELD_W-1:0]    o_press_events;
    logic [mbd_pkg::FIELD_W-1:0]    o_release_events;
    logic [mbd_pkg::FIELD_W-1:0]    o_pressed_now;

    int                             send_idle_pct  = 0;
    int                             recv_stall_pct = 0;
    logic                           hold_tgl  = 1'b0;
    logic                           hold_seen = 1'b0;
    int                             hold_left = 0;
    logic [mbd_pkg::FIELD_W-1:0]    stable_lvl = '1;
    int                             burst_left [mbd_pkg::FIELD_W];
    int                             seg_items [SEGMENTS];
    logic                           seg_polarity [SEGMENTS];
    logic [mbd_pkg::FIELD_W-1:0]    seg_enable [SEGMENTS];
    debounce_checker                chk = new();

    multi_button_history_debouncer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_levels         (i_levels),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_press_events   (o_press_events),
        .o_release_events (o_release_events),
        .o_pressed_now    (o_pressed_now),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_tgl != hold_seen) begin
            hold_seen <= hold_tgl;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                chk.compare_result(o_press_events, o_release_events, o_pressed_now);
            if (i_valid && !o_stall)
                chk.accept_tick(i_levels);
        end
    end

    task make_levels(output logic [mbd_pkg::FIELD_W-1:0] lv);
        int r;
        if ($urandom_range(9) == 0) begin
            lv = mbd_pkg::FIELD_W'($urandom);
        end else begin
            for (int i = 0; i < mbd_pkg::FIELD_W; i++) begin
                if (burst_left[i] > 0) begin
                    lv[i] = ~stable_lvl[i];
                    burst_left[i]--;
                end else begin
                    r = $urandom_range(99);
                    if (r < 3) begin
                        stable_lvl[i] = ~stable_lvl[i];
                        lv[i] = stable_lvl[i];
                    end else if (r < 8) begin
                        burst_left[i] = $urandom_range(5);
                        lv[i] = ~stable_lvl[i];
                    end else begin
                        lv[i] = stable_lvl[i];
                    end
                end
            end
        end
    endtask

    task send_tick(input logic [mbd_pkg::FIELD_W-1:0] lv);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_levels <= lv;
        do @(posedge i_clk); while (o_stall);
    endtask

    task drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (chk.pending() != 0) @(posedge i_clk);
    endtask

    task write_reg(input logic [mbd_pkg::CFG_IDX_W-1:0] idx,
                   input logic [mbd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == mbd_pkg::CFG_ACTIVE_LOW)
            chk.active_low = data[0];
        else
            chk.enable = mbd_pkg::FIELD_W'(data);
        @(posedge i_clk);
    endtask

    initial begin
        logic [mbd_pkg::FIELD_W-1:0] lv;
        for (int i = 0; i < mbd_pkg::FIELD_W; i++) burst_left[i] = 0;
        seg_items    = '{100, 100, 40, 100, 100, 130, 130};
        seg_polarity = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        seg_enable   = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};
        seg_enable[1] = mbd_pkg::FIELD_W'($urandom);
        seg_enable[4] = mbd_pkg::FIELD_W'($urandom);
        seg_enable[5] = mbd_pkg::FIELD_W'($urandom);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 22;
        recv_stall_pct = 88;
        // full press on all channels, then full release, then alternating patterns and field extremes
        repeat (12) send_tick('0);
        repeat (6) send_tick('1);
        send_tick(8'hAA);
        send_tick(8'h55);
        send_tick(8'h00);
        send_tick(8'hFF);
        drain();

        for (int s = 0; s < SEGMENTS; s++) begin
            if (s == 2) begin
                send_idle_pct  = 88;
                recv_stall_pct = 22;
            end
            if (s == 4) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_reg(mbd_pkg::CFG_ACTIVE_LOW, mbd_pkg::CFG_DATA_W'(seg_polarity[s]));
            write_reg(mbd_pkg::CFG_CHANNEL_ENABLE, mbd_pkg::CFG_DATA_W'(seg_enable[s]));
            for (int n = 0; n < seg_items[s]; n++) begin
                if (s == 5 && n == 10) hold_tgl <= ~hold_tgl;
                if (s == 3 && n == 50) drain();
                make_levels(lv);
                send_tick(lv);
            end
            drain();
        end

        repeat (4) @(posedge i_clk);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
